FILE: src/fwpid_pkg.sv
// Shared types, constants and microcode table of the flywheel speed controller.
package fwpid_pkg;

  localparam int STEP_W = 4;

  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_PGAIN    = 3'd1;
  localparam logic [2:0] REG_IGAIN    = 3'd2;
  localparam logic [2:0] REG_DGAIN    = 3'd3;
  localparam logic [2:0] REG_FULLMARK = 3'd4;
  localparam logic [2:0] REG_HALFMARK = 3'd5;

  localparam logic [15:0] TARGET_RST   = 16'd0;
  localparam logic [7:0]  PGAIN_RST    = 8'd6;
  localparam logic [7:0]  IGAIN_RST    = 8'd0;
  localparam logic [7:0]  DGAIN_RST    = 8'd6;
  localparam logic [15:0] FULLMARK_RST = 16'd2800;
  localparam logic [15:0] HALFMARK_RST = 16'd2100;

  // Reciprocals: floor(n/3) = (n*RECIP3)>>33, floor(n/10) = (n*RECIP10)>>35 for 32-bit n
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam logic [10:0] SCALE   = 11'd1250;
  localparam logic [9:0]  FRAC1   = 10'd416;
  localparam logic [9:0]  FRAC2   = 10'd833;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic               hold;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        motor_drive;
    logic signed [31:0] measured_speed;
    logic               below_target;
    logic               full_led_off;
    logic               half_led_off;
  } out_item_t;

  typedef struct packed {
    logic [15:0] target_speed;
    logic [7:0]  prop_gain;
    logic [7:0]  integ_gain;
    logic [7:0]  deriv_gain;
  } gains_t;

  typedef struct packed {
    logic [30:0]        motor_drive;
    logic signed [31:0] measured_speed;
    logic               below_target;
  } dp_res_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIFF,
    OP_MDIV3,
    OP_QUOT3,
    OP_MSCALE,
    OP_SPEED,
    OP_ERRMAG,
    OP_MDIV10,
    OP_ERR,
    OP_MPROP,
    OP_MINTEG,
    OP_MDERIV,
    OP_ACC,
    OP_OUT
  } mop_t;

  typedef struct packed {
    mop_t              op;
    logic              hold_jump;
    logic [STEP_W-1:0] dest;
    logic              last;
  } uword_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  localparam logic [STEP_W-1:0] STEP_SKIP = 4'd13;

  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w = '{op: OP_NOP, hold_jump: 1'b0, dest: '0, last: 1'b1};
    unique case (s)
      4'd0:  w = '{op: OP_DIFF,   hold_jump: 1'b1, dest: STEP_SKIP, last: 1'b0};
      4'd1:  w = '{op: OP_MDIV3,  hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd2:  w = '{op: OP_QUOT3,  hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd3:  w = '{op: OP_MSCALE, hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd4:  w = '{op: OP_SPEED,  hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd5:  w = '{op: OP_ERRMAG, hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd6:  w = '{op: OP_MDIV10, hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd7:  w = '{op: OP_ERR,    hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd8:  w = '{op: OP_MPROP,  hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd9:  w = '{op: OP_MINTEG, hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd10: w = '{op: OP_MDERIV, hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd11: w = '{op: OP_ACC,    hold_jump: 1'b0, dest: '0, last: 1'b0};
      4'd12: w = '{op: OP_OUT,    hold_jump: 1'b0, dest: '0, last: 1'b1};
      default: w = '{op: OP_NOP,  hold_jump: 1'b0, dest: '0, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

FILE: src/fwpid_dp.sv
// Datapath of the flywheel speed controller: shared multiplier, working and state registers.
module fwpid_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  fwpid_pkg::in_item_t in_item,
  input  logic               en,
  input  fwpid_pkg::mop_t    op,
  input  fwpid_pkg::gains_t  gains,
  output logic               hold,
  output fwpid_pkg::dp_res_t res
);
  import fwpid_pkg::*;

  logic [31:0]        cnt;
  logic               hold_r;
  logic [31:0]        prev_count;
  logic signed [31:0] prev_err;
  logic signed [31:0] err_sum;
  logic [31:0]        amag;
  logic               dneg;
  logic [30:0]        qa;
  logic [1:0]         ra;
  logic signed [31:0] speed;
  logic [31:0]        m;
  logic               eneg;
  logic               below;
  logic signed [31:0] err;
  logic signed [43:0] acc;
  logic signed [67:0] prod;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic [31:0]        diff;
  logic [30:0]        q3;
  logic [9:0]         frac;
  logic [40:0]        smag;
  logic signed [32:0] tdiff;
  logic [28:0]        q10;
  logic signed [32:0] sum_wide;
  logic signed [32:0] derr;

  assign diff     = cnt - prev_count;
  assign q3       = prod[63:33];
  assign q10      = prod[63:35];
  assign tdiff    = $signed({17'd0, gains.target_speed}) - $signed({speed[31], speed});
  assign sum_wide = $signed({err_sum[31], err_sum}) + $signed({err[31], err});
  assign derr     = $signed({err[31], err}) - $signed({prev_err[31], prev_err});

  always_comb begin
    unique case (ra)
      2'd1:    frac = FRAC1;
      2'd2:    frac = FRAC2;
      default: frac = '0;
    endcase
  end
  assign smag = prod[40:0] + {31'd0, frac};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_MDIV3: begin
        mul_a = $signed({2'b00, amag});
        mul_b = $signed({2'b00, RECIP3});
      end
      OP_MSCALE: begin
        mul_a = $signed({3'b000, qa});
        mul_b = $signed({23'd0, SCALE});
      end
      OP_MDIV10: begin
        mul_a = $signed({2'b00, m});
        mul_b = $signed({2'b00, RECIP10});
      end
      OP_MPROP: begin
        mul_a = $signed({{2{err[31]}}, err});
        mul_b = $signed({26'd0, gains.prop_gain});
      end
      OP_MINTEG: begin
        mul_a = $signed({{2{err_sum[31]}}, err_sum});
        mul_b = $signed({26'd0, gains.integ_gain});
      end
      OP_MDERIV: begin
        mul_a = $signed({derr[32], derr});
        mul_b = $signed({26'd0, gains.deriv_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (load) begin
      cnt    <= in_item.encoder_count;
      hold_r <= in_item.hold;
    end
    if (en) begin
      unique case (op)
        OP_DIFF: begin
          dneg <= diff[31];
          amag <= diff[31] ? (32'd0 - diff) : diff;
        end
        OP_QUOT3: begin
          qa <= q3;
          ra <= amag[1:0] - (q3[1:0] + {q3[0], 1'b0});
        end
        OP_SPEED: begin
          if (!dneg) begin
            speed <= (smag > 41'd2147483647) ? 32'sh7FFF_FFFF : $signed(smag[31:0]);
          end else begin
            speed <= (smag > 41'd2147483648) ? 32'sh8000_0000
                                             : $signed(32'd0 - smag[31:0]);
          end
        end
        OP_ERRMAG: begin
          eneg  <= tdiff[32];
          m     <= tdiff[32] ? (32'd0 - tdiff[31:0]) : tdiff[31:0];
          below <= !tdiff[32] && (tdiff != '0);
        end
        OP_ERR: begin
          err <= eneg ? $signed(32'd0 - {3'd0, q10}) : $signed({3'd0, q10});
        end
        OP_MINTEG: acc <= $signed(prod[43:0]);
        OP_MDERIV: acc <= acc + $signed(prod[43:0]);
        OP_ACC:    acc <= acc + $signed(prod[43:0]);
        default: begin
        end
      endcase
    end
    if (rst) begin
      prev_count <= '0;
      prev_err   <= '0;
      err_sum    <= '0;
    end else if (en) begin
      if (op == OP_MPROP) begin
        if (sum_wide[32] != sum_wide[31]) begin
          err_sum <= sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          err_sum <= sum_wide[31:0];
        end
      end
      if (op == OP_OUT) begin
        prev_count <= cnt;
        prev_err   <= err;
      end
    end
  end

  assign hold = hold_r;

  always_comb begin
    if (acc[43]) begin
      res.motor_drive = '0;
    end else if (|acc[42:31]) begin
      res.motor_drive = '1;
    end else begin
      res.motor_drive = acc[30:0];
    end
    res.measured_speed = speed;
    res.below_target   = below;
  end

endmodule

FILE: src/flywheel_rpm_pid.sv
// Flywheel speed controller: microcode sequencer, register port and result register.
//
// Input channel (in_valid/in_stall/in_data) takes one transaction per control
// tick: an encoder count and a hold flag. A held tick changes nothing and
// produces no output transaction; any other tick produces exactly one result
// on the output channel (out_valid/out_stall/out_data).
// Each tick runs a 13-step microprogram over one shared 34x34 multiplier.
// The result is registered by the final OP_OUT step; no new tick is taken
// until the sequencer has returned to idle.
// A held tick runs only the first step and then the skip step before the
// sequencer returns to idle and can take the next tick.
// The result register lets the next tick start while a result waits; if the
// receiver still stalls when the next result is due, the last step waits.
// The APB port holds target, the three gains and the two LED marks at byte
// addresses 0,4,...,20; write them only while the block is idle.
// Synchronous reset loads the register defaults (gains 6/0/6, marks
// 2800/2100), clears the previous count, previous error and error sum, and
// empties the result register.
module flywheel_rpm_pid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fwpid_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fwpid_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fwpid_pkg::*;

  logic [15:0] target_speed;
  logic [7:0]  prop_gain;
  logic [7:0]  integ_gain;
  logic [7:0]  deriv_gain;
  logic [15:0] full_speed_mark;
  logic [15:0] half_speed_mark;

  seq_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  uword_t            uw;
  logic              accept;
  logic              advance;
  logic              emit;
  logic              hold;
  logic              out_valid_next;
  gains_t            gains;
  dp_res_t           res;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed    <= TARGET_RST;
      prop_gain       <= PGAIN_RST;
      integ_gain      <= IGAIN_RST;
      deriv_gain      <= DGAIN_RST;
      full_speed_mark <= FULLMARK_RST;
      half_speed_mark <= HALFMARK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET:   target_speed    <= pwdata[15:0];
        REG_PGAIN:    prop_gain       <= pwdata[7:0];
        REG_IGAIN:    integ_gain      <= pwdata[7:0];
        REG_DGAIN:    deriv_gain      <= pwdata[7:0];
        REG_FULLMARK: full_speed_mark <= pwdata[15:0];
        REG_HALFMARK: half_speed_mark <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET:   prdata = {16'd0, target_speed};
      REG_PGAIN:    prdata = {24'd0, prop_gain};
      REG_IGAIN:    prdata = {24'd0, integ_gain};
      REG_DGAIN:    prdata = {24'd0, deriv_gain};
      REG_FULLMARK: prdata = {16'd0, full_speed_mark};
      REG_HALFMARK: prdata = {16'd0, half_speed_mark};
      default:      prdata = '0;
    endcase
  end

  assign gains = '{target_speed: target_speed, prop_gain: prop_gain,
                   integ_gain: integ_gain, deriv_gain: deriv_gain};

  assign in_stall = (state != SEQ_IDLE);
  assign accept   = in_valid && !in_stall;
  assign uw       = ucode(step);

  always_comb begin
    state_next = state;
    step_next  = step;
    advance    = 1'b0;
    emit       = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          state_next = SEQ_RUN;
          step_next  = '0;
        end
      end
      SEQ_RUN: begin
        advance = !((uw.op == OP_OUT) && out_valid && out_stall);
        emit    = advance && (uw.op == OP_OUT);
        if (advance) begin
          if (uw.hold_jump && hold) begin
            step_next = uw.dest;
          end else if (uw.last) begin
            state_next = SEQ_IDLE;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  fwpid_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .in_item (in_data),
    .en      (advance),
    .op      (uw.op),
    .gains   (gains),
    .hold    (hold),
    .res     (res)
  );

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (emit) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (emit) begin
      out_data.motor_drive    <= res.motor_drive;
      out_data.measured_speed <= res.measured_speed;
      out_data.below_target   <= res.below_target;
      out_data.full_led_off   <= (target_speed != full_speed_mark);
      out_data.half_led_off   <= (target_speed == full_speed_mark) ||
                                 (target_speed != half_speed_mark);
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the flywheel speed controller: predictor, driver, monitor, APB setup.
module testbench;
  import fwpid_pkg::*;

  localparam longint SPEED_NUM = 150000;
  localparam longint SPEED_DEN = 360;
  localparam longint ERR_DIV = 10;
  localparam longint S32_MAX = 2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int RAND_PHASES = 12;
  localparam int TICKS_PER_PHASE = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRESS_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  flywheel_rpm_pid dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // register mirror
  logic [15:0] cfg_target = TARGET_RST;
  logic [7:0]  cfg_kp = PGAIN_RST;
  logic [7:0]  cfg_ki = IGAIN_RST;
  logic [7:0]  cfg_kd = DGAIN_RST;
  logic [15:0] cfg_full = FULLMARK_RST;
  logic [15:0] cfg_half = HALFMARK_RST;

  // controller state
  logic [31:0] prev_count = '0;
  longint      prev_err = 0;
  longint      err_sum = 0;

  in_item_t  tick_queue[$];
  out_item_t pending_results[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_held = 0;
  int  n_checked = 0;
  int  n_settings = 0;
  int  n_errors = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  rcv_gap = 0;
  int  press_left = 0;
  bit  idle_on = 1'b1;
  bit  press_arm = 1'b0;
  bit  press_fired = 1'b0;
  logic in_taken = 1'b0;
  logic rcv_stall = 1'b0;
  logic press_on = 1'b0;

  assign out_stall = rcv_stall | press_on;

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic out_item_t controller_tick(input logic [31:0] count);
    logic [31:0] delta;
    longint spd, tgt, err, drv, kp, ki, kd;
    out_item_t r;
    delta = count - prev_count;
    spd = $signed(delta);
    spd = clamp_s32(spd * SPEED_NUM / SPEED_DEN);
    tgt = cfg_target;
    kp = cfg_kp;
    ki = cfg_ki;
    kd = cfg_kd;
    err = (tgt - spd) / ERR_DIV;
    err_sum = clamp_s32(err_sum + err);
    drv = kp * err + ki * err_sum + kd * (err - prev_err);
    if (drv < 0) drv = 0;
    if (drv > S32_MAX) drv = S32_MAX;
    r.motor_drive = drv[30:0];
    r.measured_speed = spd[31:0];
    r.below_target = (spd < tgt);
    r.full_led_off = (cfg_target != cfg_full);
    r.half_led_off = !(cfg_target == cfg_half && cfg_target != cfg_full);
    prev_err = err;
    prev_count = count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (n_errors < MAX_PRINTED)
      $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected transaction, drive", got.motor_drive, -1);
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    if (got.motor_drive !== want.motor_drive)
      report_mismatch("motor_drive", got.motor_drive, want.motor_drive);
    if (got.measured_speed !== want.measured_speed)
      report_mismatch("measured_speed", got.measured_speed, want.measured_speed);
    if (got.below_target !== want.below_target)
      report_mismatch("below_target", got.below_target, want.below_target);
    if (got.full_led_off !== want.full_led_off)
      report_mismatch("full_led_off", got.full_led_off, want.full_led_off);
    if (got.half_led_off !== want.half_led_off)
      report_mismatch("half_led_off", got.half_led_off, want.half_led_off);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= tick_queue.pop_front();
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall bursts
  always @(negedge clk) begin
    if (rst) begin
      rcv_stall <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      rcv_stall <= 1'b1;
    end else begin
      rcv_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 4) == 0) rcv_gap = $urandom_range(1, 19);
    end
  end

  // one long hold-off so the block backs up into its input
  always @(negedge clk) begin
    if (rst) begin
      press_on <= 1'b0;
    end else if (press_left > 0) begin
      press_left--;
      press_on <= (press_left != 0);
    end else if (press_arm && !press_fired) begin
      press_fired = 1'b1;
      press_left = PRESS_CYCLES;
      press_on <= 1'b1;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        n_accepted++;
        if (in_data.hold) n_held++;
        else pending_results.push_back(controller_tick(in_data.encoder_count));
      end
      if (out_valid && !out_stall) check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET:   cfg_target = val[15:0];
      REG_PGAIN:    cfg_kp = val[7:0];
      REG_IGAIN:    cfg_ki = val[7:0];
      REG_DGAIN:    cfg_kd = val[7:0];
      REG_FULLMARK: cfg_full = val[15:0];
      REG_HALFMARK: cfg_half = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] t, input logic [7:0] kp, input logic [7:0] ki,
                                input logic [7:0] kd, input logic [15:0] fm,
                                input logic [15:0] hm);
    reg_write(REG_TARGET, {16'd0, t});
    reg_write(REG_PGAIN, {24'd0, kp});
    reg_write(REG_IGAIN, {24'd0, ki});
    reg_write(REG_DGAIN, {24'd0, kd});
    reg_write(REG_FULLMARK, {16'd0, fm});
    reg_write(REG_HALFMARK, {16'd0, hm});
    n_settings++;
  endtask

  task automatic queue_tick(input logic [31:0] count, input logic hold);
    in_item_t it;
    it.encoder_count = count;
    it.hold = hold;
    tick_queue.push_back(it);
    n_queued++;
  endtask

  // all transactions through, then enough cycles for a trailing held tick
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(500, 5000));
    endcase
  endfunction

  function automatic logic [7:0] pick_u8();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return 8'($urandom_range(0, 12));
    endcase
  endfunction

  // mostly plausible encoder motion, with jumps, wild counts and held ticks
  task automatic random_ticks(input int n);
    logic [31:0] cur;
    int sel;
    cur = prev_count;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        queue_tick($urandom, 1'b1);
      end else begin
        if (sel < 72) cur = cur + $urandom_range(0, 180);
        else if (sel < 80) cur = cur - $urandom_range(0, 40);
        else if (sel < 90) cur = cur + $urandom_range(0, 3000);
        else cur = $urandom;
        queue_tick(cur, 1'b0);
      end
    end
  endtask

  initial begin
    logic [15:0] t;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset defaults: zero motion, small motion, wraparound and saturation
    queue_tick(32'd0, 1'b0);
    queue_tick(32'd12, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    queue_tick(32'd12, 1'b0);
    queue_tick(32'h7FFF_FFFF, 1'b0);
    queue_tick(32'h8000_0000, 1'b0);
    queue_tick(32'h0000_0000, 1'b0);
    queue_tick(32'h8000_0000, 1'b1);
    queue_tick(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    // target on the full mark, max gains, drive the error sum into saturation
    apply_settings(16'd2800, 8'hFF, 8'hFF, 8'hFF, 16'd2800, 16'd2100);
    for (int k = 0; k < 11; k++) queue_tick(k[0] ? 32'h0 : 32'h8000_0000, 1'b0);
    wait_drained();

    // target on the half mark only, zero gains, writes past the register map
    apply_settings(16'd2100, 8'd0, 8'd0, 8'd0, 16'd2800, 16'd2100);
    reg_write(REG_SPARE6, $urandom);
    reg_write(REG_SPARE7, $urandom);
    queue_tick(32'h0000_0100, 1'b0);
    wait_drained();

    // both marks equal the target
    apply_settings(16'hFFFF, 8'd1, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
    queue_tick(32'h0000_0100, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        idle_on = 1'b1;
        press_arm = 1'b1;
      end
      t = pick_u16();
      apply_settings(t, pick_u8(), pick_u8(), pick_u8(),
                     ($urandom_range(0, 3) == 0) ? t : pick_u16(),
                     ($urandom_range(0, 3) == 0) ? t : pick_u16());
      random_ticks(TICKS_PER_PHASE);
      wait_drained();
    end

    if (pending_results.size() != 0)
      report_mismatch("results never produced", pending_results.size(), 0);
    $display("run covered %0d ticks (%0d held) under %0d register settings",
             n_accepted, n_held, n_settings);
    $display("%0d results checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
